// File: hdl/iase_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iase_pkg
// Shared sizes, operation and status codes and the storage request bundle of
// the indexed array stack engine.
// ----------------------------------------------------------------------------
package iase_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	localparam int FUNC_BITS   = 4;
	localparam int INDEX_BITS  = 5;
	localparam int VALUE_BITS  = 32;
	localparam int DATA_BITS   = 32;
	localparam int FILL_BITS   = 5;
	localparam int STATUS_BITS = 2;

	localparam int CMP_BITS = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

	// slave tdata: index, value; master tdata: data_out, fill_count
	localparam int INDEX_LSB    = 0;
	localparam int VALUE_LSB    = INDEX_LSB + INDEX_BITS;
	localparam int S_TDATA_BITS = ((VALUE_LSB + VALUE_BITS + 7) / 8) * 8;
	localparam int DATA_LSB     = 0;
	localparam int FILL_LSB     = DATA_LSB + DATA_BITS;
	localparam int M_TDATA_BITS = ((FILL_LSB + FILL_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_PUSH        = 4'd0,
		FN_POP         = 4'd1,
		FN_BACK        = 4'd2,
		FN_GET         = 4'd3,
		FN_SET         = 4'd4,
		FN_SWAP_BACK   = 4'd5,
		FN_REMOVE_UNORD = 4'd6,
		FN_REMOVE      = 4'd7,
		FN_INSERT      = 4'd8
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [WORD_BITS-1:0] wdata;
		logic [ADDR_BITS-1:0] raddr;
	} mem_req_t;

endpackage

// File: hdl/iase_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iase_store
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iase_store (
	input  logic                        clk,
	input  iase_pkg::mem_req_t          req,
	output logic [iase_pkg::WORD_BITS-1:0] rdata
);
	import iase_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/indexed_array_stack_engine.sv
`timescale 1ns / 1ps
// Ordered remove and insert shift the entries between the index and the top,
// one entry moved per cycle through the read and write ports of the storage.
// One item at a time. Reset clears the fill count, the sequencer and the
// result valid flag; entry storage and result data are not cleared.
// ----------------------------------------------------------------------------
// indexed_array_stack_engine
// Fixed-capacity array with fill count, driven by a small sequencer over one
// storage port pair.
// ----------------------------------------------------------------------------
module indexed_array_stack_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [iase_pkg::S_TDATA_BITS-1:0] s_axis_tdata,  // index, value
	input  logic [iase_pkg::FUNC_BITS-1:0]    s_axis_tuser,  // func
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [iase_pkg::M_TDATA_BITS-1:0] m_axis_tdata,  // data_out, fill_count
	output logic [iase_pkg::STATUS_BITS-1:0]  m_axis_tuser   // status
);
	import iase_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_CAP,
		S_SW_RD2,
		S_SW_WR1,
		S_SW_WR2,
		S_UR_CAP,
		S_UR_WR,
		S_RM_CAP,
		S_MOVE,
		S_DONE
	} state_t;

	state_t               state_q;
	func_t                func_q;
	logic [ADDR_BITS-1:0] idx_q;
	logic [WORD_BITS-1:0] val_q;
	logic [WORD_BITS-1:0] hold_q;
	logic [WORD_BITS-1:0] data_q;
	status_t              status_q;
	logic [CNT_BITS-1:0]  fill_q;
	logic [ADDR_BITS-1:0] src_q;
	logic [ADDR_BITS-1:0] dst_q;
	logic [CNT_BITS-1:0]  moves_q;
	logic                 pend_q;
	logic                 out_valid_q;
	logic [DATA_BITS-1:0] out_data_q;
	logic [FILL_BITS-1:0] out_fill_q;
	status_t              out_status_q;

	func_t                in_func;
	logic [INDEX_BITS-1:0] in_index;
	logic [WORD_BITS-1:0] in_word;
	logic [ADDR_BITS-1:0] in_addr;
	logic [CMP_BITS-1:0]  ixx;
	logic [CMP_BITS-1:0]  fillx;
	logic                 in_xfer;
	logic                 full;
	logic                 empty;
	logic                 idx_ge_fill;
	logic                 idx_gt_fill;
	logic                 idx_eq_fill;
	logic [ADDR_BITS-1:0] last_addr;
	logic [ADDR_BITS-1:0] src_step;
	logic [ADDR_BITS-1:0] dst_step;
	logic                 move_up;
	mem_req_t             req;
	logic [WORD_BITS-1:0] rdata;

	assign in_func  = func_t'(s_axis_tuser);
	assign in_index = s_axis_tdata[INDEX_LSB +: INDEX_BITS];
	assign in_word  = WORD_BITS'(s_axis_tdata[VALUE_LSB +: VALUE_BITS]);
	assign in_addr  = ADDR_BITS'(in_index);
	assign ixx      = CMP_BITS'(in_index);
	assign fillx    = CMP_BITS'(fill_q);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign full        = (fill_q == CNT_BITS'(DEPTH));
	assign empty       = (fill_q == '0);
	assign idx_ge_fill = (ixx >= fillx);
	assign idx_gt_fill = (ixx > fillx);
	assign idx_eq_fill = (ixx == fillx);
	assign last_addr   = ADDR_BITS'(fill_q - CNT_BITS'(1));

	// ordered remove walks upwards, insert walks down from the top
	assign move_up  = (func_q == FN_REMOVE);
	assign src_step = move_up ? src_q + ADDR_BITS'(1) : src_q - ADDR_BITS'(1);
	assign dst_step = move_up ? dst_q + ADDR_BITS'(1) : dst_q - ADDR_BITS'(1);

	// storage port control
	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (in_func)
						FN_PUSH: begin
							req.we    = !full;
							req.waddr = ADDR_BITS'(fill_q);
							req.wdata = in_word;
						end
						FN_POP, FN_BACK: begin
							req.raddr = last_addr;
						end
						FN_SET: begin
							req.we    = !idx_gt_fill && !(idx_eq_fill && full);
							req.waddr = in_addr;
							req.wdata = in_word;
						end
						default: begin
							req.raddr = in_addr;
						end
					endcase
				end
			end
			S_SW_RD2, S_UR_CAP: begin
				req.raddr = last_addr;
			end
			S_SW_WR1, S_UR_WR: begin
				req.we    = 1'b1;
				req.waddr = idx_q;
				req.wdata = rdata;
			end
			S_SW_WR2: begin
				req.we    = 1'b1;
				req.waddr = last_addr;
				req.wdata = hold_q;
			end
			S_MOVE: begin
				req.raddr = src_q;
				if (pend_q) begin
					req.we    = 1'b1;
					req.waddr = dst_q;
					req.wdata = rdata;
				end else if (moves_q == '0 && func_q == FN_INSERT) begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = val_q;
				end
			end
			default: begin
				req = '0;
			end
		endcase
	end

	iase_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			moves_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						func_q   <= in_func;
						idx_q    <= in_addr;
						val_q    <= in_word;
						data_q   <= '0;
						status_q <= STAT_OK;
						pend_q   <= 1'b0;
						state_q  <= S_DONE;
						case (in_func)
							FN_PUSH: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									fill_q <= fill_q + CNT_BITS'(1);
								end
							end
							FN_POP: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									fill_q  <= fill_q - CNT_BITS'(1);
									state_q <= S_RD_CAP;
								end
							end
							FN_BACK: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_RD_CAP;
								end
							end
							FN_GET: begin
								if (idx_ge_fill) begin
									status_q <= STAT_RANGE;
								end else begin
									state_q <= S_RD_CAP;
								end
							end
							FN_SET: begin
								if (idx_gt_fill) begin
									status_q <= STAT_RANGE;
								end else if (idx_eq_fill) begin
									if (full) begin
										status_q <= STAT_FULL;
									end else begin
										fill_q <= fill_q + CNT_BITS'(1);
									end
								end
							end
							FN_SWAP_BACK: begin
								if (idx_ge_fill) begin
									status_q <= STAT_RANGE;
								end else begin
									state_q <= S_SW_RD2;
								end
							end
							FN_REMOVE_UNORD: begin
								if (idx_ge_fill) begin
									status_q <= STAT_RANGE;
								end else begin
									state_q <= S_UR_CAP;
								end
							end
							FN_REMOVE: begin
								if (idx_ge_fill) begin
									status_q <= STAT_RANGE;
								end else begin
									fill_q  <= fill_q - CNT_BITS'(1);
									src_q   <= in_addr + ADDR_BITS'(1);
									dst_q   <= in_addr;
									moves_q <= CNT_BITS'(fillx - ixx - CMP_BITS'(1));
									state_q <= S_RM_CAP;
								end
							end
							FN_INSERT: begin
								if (idx_gt_fill) begin
									status_q <= STAT_RANGE;
								end else if (full) begin
									status_q <= STAT_FULL;
								end else begin
									fill_q  <= fill_q + CNT_BITS'(1);
									src_q   <= last_addr;
									dst_q   <= ADDR_BITS'(fill_q);
									moves_q <= CNT_BITS'(fillx - ixx);
									state_q <= S_MOVE;
								end
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				S_RD_CAP: begin
					data_q  <= rdata;
					state_q <= S_DONE;
				end
				S_SW_RD2: begin
					hold_q  <= rdata;
					state_q <= S_SW_WR1;
				end
				S_SW_WR1: begin
					state_q <= S_SW_WR2;
				end
				S_SW_WR2: begin
					state_q <= S_DONE;
				end
				S_UR_CAP: begin
					data_q  <= rdata;
					state_q <= S_UR_WR;
				end
				S_UR_WR: begin
					fill_q  <= fill_q - CNT_BITS'(1);
					state_q <= S_DONE;
				end
				S_RM_CAP: begin
					data_q  <= rdata;
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					// read one entry ahead, write the previous read behind it
					if (moves_q != '0) begin
						src_q   <= src_step;
						moves_q <= moves_q - CNT_BITS'(1);
					end
					pend_q <= (moves_q != '0);
					if (pend_q) begin
						dst_q <= dst_step;
					end
					if (moves_q == '0 && !pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= DATA_BITS'(data_q);
						out_fill_q   <= FILL_BITS'(fill_q);
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_BITS'({out_fill_q, out_data_q});
	assign m_axis_tuser  = out_status_q;

endmodule

// File: hdl/iase_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iase_checker
// Port-level checks on the result stream of the indexed array stack engine.
// ----------------------------------------------------------------------------
module iase_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [iase_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	input logic [iase_pkg::STATUS_BITS-1:0]  m_axis_tuser
);
	import iase_pkg::*;

	logic [DATA_BITS-1:0] out_data;
	logic [FILL_BITS-1:0] out_fill;

	assign out_data = m_axis_tdata[DATA_LSB +: DATA_BITS];
	assign out_fill = m_axis_tdata[FILL_LSB +: FILL_BITS];

	// a failed operation returns no word
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> out_data == '0)
		else $error("error result carries data");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> out_fill == '0)
		else $error("empty status with non-zero fill");

	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_FULL |-> out_fill == FILL_BITS'(DEPTH))
		else $error("full status below capacity");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_fill <= FILL_BITS'(DEPTH))
		else $error("fill count above capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind indexed_array_stack_engine iase_checker u_iase_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the indexed array stack engine with directed and random operations,
// keeps a shadow copy of the array to work out each reply, and compares every
// reply transfer field by field. Both stream sides idle at random, and one
// phase holds the reply side off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import iase_pkg::*;

	typedef struct packed {
		logic [DATA_BITS-1:0] data;
		logic [FILL_BITS-1:0] fill;
		status_t              st;
	} array_reply_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [S_TDATA_BITS-1:0] s_axis_tdata;
	logic [FUNC_BITS-1:0]    s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [M_TDATA_BITS-1:0] m_axis_tdata;
	logic [STATUS_BITS-1:0]  m_axis_tuser;

	logic [WORD_BITS-1:0] shadow_words [DEPTH];
	int                   shadow_fill;
	array_reply_t         pending_replies [$];
	int unsigned          fail_count;
	bit                   idle_on;
	int                   hold_cycles;
	int                   hold_reqs;

	indexed_array_stack_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Apply one operation to the shadow array and return the reply it gives.
	function automatic array_reply_t apply_array_op(logic [FUNC_BITS-1:0] op,
			logic [INDEX_BITS-1:0] ix, logic [VALUE_BITS-1:0] v);
		array_reply_t         r;
		logic [WORD_BITS-1:0] held;
		int                   pos;
		pos    = int'(ix);
		r.data = '0;
		r.st   = STAT_OK;
		case (op)
			FN_PUSH: begin
				if (shadow_fill >= DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					shadow_words[shadow_fill] = v;
					shadow_fill++;
				end
			end
			FN_POP: begin
				if (shadow_fill == 0) begin
					r.st = STAT_EMPTY;
				end else begin
					shadow_fill--;
					r.data = shadow_words[shadow_fill];
				end
			end
			FN_BACK: begin
				if (shadow_fill == 0)
					r.st = STAT_EMPTY;
				else
					r.data = shadow_words[shadow_fill - 1];
			end
			FN_GET: begin
				if (pos >= shadow_fill)
					r.st = STAT_RANGE;
				else
					r.data = shadow_words[pos];
			end
			FN_SET: begin
				if (pos > shadow_fill) begin
					r.st = STAT_RANGE;
				end else if (pos == shadow_fill) begin
					if (shadow_fill >= DEPTH) begin
						r.st = STAT_FULL;
					end else begin
						shadow_words[shadow_fill] = v;
						shadow_fill++;
					end
				end else begin
					shadow_words[pos] = v;
				end
			end
			FN_SWAP_BACK: begin
				if (pos >= shadow_fill) begin
					r.st = STAT_RANGE;
				end else begin
					held                           = shadow_words[pos];
					shadow_words[pos]              = shadow_words[shadow_fill - 1];
					shadow_words[shadow_fill - 1]  = held;
				end
			end
			FN_REMOVE_UNORD: begin
				if (pos >= shadow_fill) begin
					r.st = STAT_RANGE;
				end else begin
					r.data            = shadow_words[pos];
					shadow_words[pos] = shadow_words[shadow_fill - 1];
					shadow_fill--;
				end
			end
			FN_REMOVE: begin
				if (pos >= shadow_fill) begin
					r.st = STAT_RANGE;
				end else begin
					r.data = shadow_words[pos];
					shadow_fill--;
					for (int i = pos; i < shadow_fill; i++)
						shadow_words[i] = shadow_words[i + 1];
				end
			end
			FN_INSERT: begin
				if (pos > shadow_fill) begin
					r.st = STAT_RANGE;
				end else if (shadow_fill >= DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					for (int i = shadow_fill; i > pos; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[pos] = v;
					shadow_fill++;
				end
			end
			default: ;
		endcase
		r.fill = shadow_fill[FILL_BITS-1:0];
		return r;
	endfunction

	// Offer one operation and record its reply once the transfer is taken.
	task automatic send_op(logic [FUNC_BITS-1:0] op, logic [INDEX_BITS-1:0] ix,
			logic [VALUE_BITS-1:0] v);
		logic [S_TDATA_BITS-1:0] payload;
		int                      gap;
		gap = (idle_on && $urandom_range(99) < 18) ? $urandom_range(1, 5) : 0;
		payload = '0;
		payload[INDEX_LSB +: INDEX_BITS] = ix;
		payload[VALUE_LSB +: VALUE_BITS] = v;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = payload;
		do @(posedge clk); while (!s_axis_tready);
		pending_replies.push_back(apply_array_op(op, ix, v));
	endtask

	task automatic send_random_op(int grow_pct);
		logic [FUNC_BITS-1:0]  op;
		logic [INDEX_BITS-1:0] ix;
		logic [VALUE_BITS-1:0] v;
		int                    pick;
		pick = $urandom_range(99);
		case ($urandom_range(7))
			0:       v = '0;
			1:       v = '1;
			default: v = $urandom();
		endcase
		if ($urandom_range(9) < 8)
			ix = INDEX_BITS'($urandom_range(0, shadow_fill));
		else
			ix = INDEX_BITS'($urandom_range(0, 31));
		if (pick < 4) begin
			op = FUNC_BITS'($urandom_range(9, 15));
		end else if ($urandom_range(99) < grow_pct) begin
			case ($urandom_range(2))
				0:       op = FN_PUSH;
				1:       op = FN_INSERT;
				default: begin
					op = FN_SET;
					ix = shadow_fill[INDEX_BITS-1:0];
				end
			endcase
		end else begin
			op = FUNC_BITS'($urandom_range(0, 8));
		end
		send_op(op, ix, v);
	endtask

	task automatic test_empty_errors();
		send_op(FN_POP, 5'd0, 32'h0);
		send_op(FN_BACK, 5'd0, 32'h0);
		send_op(FN_GET, 5'd0, 32'h0);
		send_op(FN_GET, 5'd31, 32'hFFFF_FFFF);
		send_op(FN_SWAP_BACK, 5'd0, 32'h0);
		send_op(FN_REMOVE_UNORD, 5'd0, 32'h0);
		send_op(FN_REMOVE, 5'd0, 32'h0);
		send_op(FN_SET, 5'd1, 32'h1234_5678);
		send_op(FN_INSERT, 5'd1, 32'h8765_4321);
		send_op(4'd15, 5'd31, 32'hFFFF_FFFF);
	endtask

	task automatic test_basic_ops();
		send_op(FN_SET, 5'd0, 32'hFFFF_FFFF);
		send_op(FN_PUSH, 5'd0, 32'h0000_0000);
		send_op(FN_INSERT, 5'd0, 32'hA5A5_A5A5);
		send_op(FN_INSERT, 5'd3, 32'h5A5A_5A5A);
		send_op(FN_BACK, 5'd0, 32'h0);
		send_op(FN_GET, 5'd1, 32'h0);
		send_op(FN_SET, 5'd1, 32'h0F0F_F0F0);
		send_op(FN_SWAP_BACK, 5'd3, 32'h0);
		send_op(FN_SWAP_BACK, 5'd0, 32'h0);
		send_op(FN_REMOVE_UNORD, 5'd1, 32'h0);
		send_op(FN_REMOVE, 5'd0, 32'h0);
		send_op(4'd9, 5'd2, 32'hDEAD_BEEF);
		send_op(FN_POP, 5'd0, 32'h0);
		send_op(FN_POP, 5'd0, 32'h0);
	endtask

	task automatic test_array_at_capacity();
		while (shadow_fill < DEPTH) begin
			if ($urandom_range(1))
				send_op(FN_PUSH, 5'd0, $urandom());
			else
				send_op(FN_INSERT, INDEX_BITS'($urandom_range(0, shadow_fill)),
					$urandom());
		end
		send_op(FN_PUSH, 5'd0, 32'h1111_1111);
		send_op(FN_SET, 5'd16, 32'h2222_2222);
		send_op(FN_INSERT, 5'd0, 32'h3333_3333);
		send_op(FN_INSERT, 5'd16, 32'h4444_4444);
		// out of range wins over full
		send_op(FN_INSERT, 5'd17, 32'h5555_5555);
		send_op(FN_SET, 5'd17, 32'h6666_6666);
		send_op(FN_GET, 5'd15, 32'h0);
		send_op(FN_BACK, 5'd0, 32'h0);
		// longest shifts in both directions
		send_op(FN_REMOVE, 5'd0, 32'h0);
		send_op(FN_INSERT, 5'd0, 32'h7777_7777);
		send_op(FN_SWAP_BACK, 5'd15, 32'h0);
	endtask

	task automatic test_reply_backpressure();
		// hold the reply side off so the engine fills and stalls its input
		@(negedge clk);
		hold_reqs++;
		repeat (12) send_random_op(50);
	endtask

	task automatic test_random_ops(int count, int grow_pct);
		repeat (count) send_random_op(grow_pct);
	endtask

	initial begin
		int hold_seen;
		hold_seen     = 0;
		hold_cycles   = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen   = hold_reqs;
				hold_cycles = 300;
			end
			if (hold_cycles > 0) begin
				m_axis_tready = 1'b0;
				hold_cycles--;
			end else if (!idle_on) begin
				m_axis_tready = 1'b1;
			end else begin
				m_axis_tready = ($urandom_range(99) >= 18);
			end
		end
	end

	always @(posedge clk) begin
		array_reply_t         want;
		logic [DATA_BITS-1:0] got_data;
		logic [FILL_BITS-1:0] got_fill;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_data = m_axis_tdata[DATA_LSB +: DATA_BITS];
			got_fill = m_axis_tdata[FILL_LSB +: FILL_BITS];
			if (pending_replies.size() == 0) begin
				$error("reply transfer with none outstanding: data_out %0h", got_data);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (got_data !== want.data) begin
					$error("data_out: expected %0h, actual %0h", want.data, got_data);
					fail_count++;
				end
				if (got_fill !== want.fill) begin
					$error("fill_count: expected %0d, actual %0d", want.fill, got_fill);
					fail_count++;
				end
				if (m_axis_tuser !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		shadow_fill   = 0;
		fail_count    = 0;
		idle_on       = 1'b1;
		hold_reqs     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_errors();
		test_basic_ops();
		test_array_at_capacity();
		test_reply_backpressure();
		test_random_ops(500, 65);
		idle_on = 1'b0;
		test_random_ops(250, 50);
		idle_on = 1'b1;
		test_random_ops(400, 30);
		test_random_ops(400, 55);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
